// ===== rtl/core/particle_pair_force_step_core_assert.svh =====
// ----------------------------------------------------------------------------
// Particle pair force step: assertion macros
// Shared concurrent assertion forms for the force step core.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_PAIR_FORCE_STEP_CORE_ASSERT_SVH
`define PARTICLE_PAIR_FORCE_STEP_CORE_ASSERT_SVH

// Check a condition at every edge outside reset.
`define PPFS_ASSERT_NOW(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle.
`define PPFS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the next cycle.
`define PPFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ppfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Particle pair force step: package
// Types, codes and constants of the force step core.
// ----------------------------------------------------------------------------
package ppfs_pkg;

    localparam int unsigned MAX_TARGETS_DEF = 64;
    localparam int unsigned MAX_SOURCES_DEF = 64;

    localparam int unsigned CFG_IDXW = 3;
    localparam int unsigned IDX_OUTW = 6;

    localparam logic signed [31:0] STRENGTH_RST = 32'sd65536;
    localparam logic [15:0]        AREA_W_RST   = 16'd1024;
    localparam logic [15:0]        AREA_H_RST   = 16'd768;
    localparam logic [15:0]        CUTOFF_RST   = 16'd80;

    localparam logic [6:0] SQRT_LAST = 7'd31;
    localparam logic [6:0] DIV_LAST  = 7'd63;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        CMD_LOAD_TGT = 2'd0,
        CMD_LOAD_SRC = 2'd1,
        CMD_RUN      = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDXW-1:0] {
        CFG_STRENGTH = 3'd0,
        CFG_AREA_W   = 3'd1,
        CFG_AREA_H   = 3'd2,
        CFG_CUTOFF   = 3'd3,
        CFG_SAME_SET = 3'd4
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_T_RD,
        ST_T_CAP,
        ST_S_RD,
        ST_S_CAP,
        ST_SQ1,
        ST_SQ2,
        ST_CHK,
        ST_SQRT,
        ST_MULX,
        ST_MULY,
        ST_DIV,
        ST_ACC,
        ST_NEXT,
        ST_UPD1,
        ST_UPD2
    } t_state;

endpackage

// ===== rtl/core/particle_pair_force_step_core.sv =====
// ----------------------------------------------------------------------------
// Particle pair force step core
// Pairwise Q16.16 force, velocity and position update over stored particles.
// ----------------------------------------------------------------------------
// Load words are accepted back to back.
// A run word walks targets in order and, per source, forms the squared distance;
// a pair inside the cutoff goes on through a 32-step root and a 64-step divide,
// one outside is skipped; no word is taken until the pass ends.
// Results leave through one output register, one per target.
// Synchronous active-low reset clears counts, config and control; stores are not cleared.
`include "particle_pair_force_step_core_assert.svh"

module particle_pair_force_step_core #(
    parameter int unsigned MAX_TARGETS = ppfs_pkg::MAX_TARGETS_DEF,
    parameter int unsigned MAX_SOURCES = ppfs_pkg::MAX_SOURCES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // register write port
    input  logic                          i_cfg_wr_en,
    input  logic [ppfs_pkg::CFG_IDXW-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    // input words
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [127:0]                  s_axis_tdata,  // pos_x, pos_y, vel_x, vel_y
    input  logic [1:0]                    s_axis_tuser,  // cmd
    // result words
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [127:0]                  m_axis_tdata,  // new_pos_x, new_pos_y, new_vel_x, new_vel_y
    output logic [ppfs_pkg::IDX_OUTW-1:0] m_axis_tuser,  // target_index
    output logic                          m_axis_tlast   // last
);

    localparam int unsigned TIW  = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int unsigned SIW  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int unsigned TCW  = $clog2(MAX_TARGETS + 1);
    localparam int unsigned SCW  = $clog2(MAX_SOURCES + 1);
    localparam int unsigned NCW  = (TCW > SCW) ? TCW : SCW;
    localparam int unsigned NMAX = (MAX_TARGETS > MAX_SOURCES) ? MAX_TARGETS : MAX_SOURCES;
    // a term is below 2^64 in magnitude; room for NMAX of them plus sign
    localparam int unsigned ACCW = 66 + $clog2(NMAX + 1);

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic signed [31:0] r_strength;
    logic [15:0]        r_area_w;
    logic [15:0]        r_area_h;
    logic [15:0]        r_cutoff;
    logic               r_same_set;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength <= ppfs_pkg::STRENGTH_RST;
            r_area_w   <= ppfs_pkg::AREA_W_RST;
            r_area_h   <= ppfs_pkg::AREA_H_RST;
            r_cutoff   <= ppfs_pkg::CUTOFF_RST;
            r_same_set <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (ppfs_pkg::t_cfg_reg'(i_cfg_index))
                ppfs_pkg::CFG_STRENGTH: r_strength <= $signed(i_cfg_data);
                ppfs_pkg::CFG_AREA_W:   r_area_w   <= i_cfg_data[15:0];
                ppfs_pkg::CFG_AREA_H:   r_area_h   <= i_cfg_data[15:0];
                ppfs_pkg::CFG_CUTOFF:   r_cutoff   <= i_cfg_data[15:0];
                ppfs_pkg::CFG_SAME_SET: r_same_set <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Particle stores: target word {vy, vx, py, px}, source word {py, px}.
    // Each has one write and one read per cycle, read data registered.
    // ------------------------------------------------------------------------
    logic [127:0] r_tmem [MAX_TARGETS];
    logic [63:0]  r_smem [MAX_SOURCES];
    logic [127:0] r_trd;
    logic [63:0]  r_srd;

    logic           tmem_we;
    logic [TIW-1:0] tmem_waddr;
    logic [127:0]   tmem_wdata;
    logic           tmem_re;
    logic [TIW-1:0] tmem_raddr;
    logic           smem_we;
    logic [SIW-1:0] smem_waddr;
    logic           smem_re;
    logic [SIW-1:0] smem_raddr;

    always_ff @(posedge i_clk) begin
        if (tmem_we) begin
            r_tmem[tmem_waddr] <= tmem_wdata;
        end
        if (tmem_re) begin
            r_trd <= r_tmem[tmem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (smem_we) begin
            r_smem[smem_waddr] <= s_axis_tdata[63:0];
        end
        if (smem_re) begin
            r_srd <= r_smem[smem_raddr];
        end
    end

    // ------------------------------------------------------------------------
    // Pass control and datapath registers
    // ------------------------------------------------------------------------
    ppfs_pkg::t_state r_state, n_state;

    logic [TCW-1:0] r_tcnt;
    logic [SCW-1:0] r_scnt;
    logic [TCW-1:0] r_i;
    logic [NCW-1:0] r_j;
    logic [NCW-1:0] r_n;
    logic [6:0]     r_cnt;

    logic signed [31:0] r_tpx, r_tpy, r_tvx, r_tvy;
    logic signed [32:0] r_dx, r_dy;
    logic [64:0]        r_a2;
    logic [65:0]        r_d2;
    logic [63:0]        r_rem, r_root, r_bit;
    logic [31:0]        r_dist;
    logic [63:0]        r_nx, r_ny;
    logic [31:0]        r_rx, r_ry;
    logic signed [ACCW-1:0] r_fx, r_fy;

    logic         r_ovalid;
    logic [127:0] r_odata;
    logic [ppfs_pkg::IDX_OUTW-1:0] r_oidx;
    logic         r_olast;

    // handshake and strobes
    logic in_fire;
    logic out_free;
    logic out_load;
    logic pass_last_tgt;
    logic pair_last;

    assign s_axis_tready = (r_state == ppfs_pkg::ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;
    assign pass_last_tgt = ({1'b0, r_i} + 1'b1) == {1'b0, r_tcnt};
    assign pair_last     = ({1'b0, r_j} + 1'b1) == {1'b0, r_n};

    // ------------------------------------------------------------------------
    // Pair arithmetic
    // ------------------------------------------------------------------------
    logic [32:0] ax, ay;
    logic [31:0] as_mag;
    logic [31:0] lim32;
    logic        pair_in;
    logic [63:0] sq_rb;
    logic        sq_take;
    logic [32:0] dv_tx, dv_ty;
    logic        dv_qx, dv_qy;
    logic        term_neg_x, term_neg_y;
    logic signed [ACCW-1:0] qx_ext, qy_ext, term_x, term_y;
    logic signed [31:0] src_px, src_py;

    assign ax     = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
    assign ay     = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
    assign as_mag = r_strength[31] ? 32'(-r_strength) : 32'(r_strength);
    assign lim32  = 32'(r_cutoff * r_cutoff);
    assign pair_in = (r_d2 != 66'd0) && (r_d2 < {2'b00, lim32, 32'd0});

    assign src_px = r_same_set ? $signed(r_trd[31:0])  : $signed(r_srd[31:0]);
    assign src_py = r_same_set ? $signed(r_trd[63:32]) : $signed(r_srd[63:32]);

    // one step of the bit-pair square root
    assign sq_rb   = r_root + r_bit;
    assign sq_take = (r_rem >= sq_rb);

    // one step of the restoring divide, both axes
    assign dv_tx = {r_rx, r_nx[63]};
    assign dv_ty = {r_ry, r_ny[63]};
    assign dv_qx = (dv_tx >= {1'b0, r_dist});
    assign dv_qy = (dv_ty >= {1'b0, r_dist});

    assign term_neg_x = r_dx[32] ^ r_strength[31];
    assign term_neg_y = r_dy[32] ^ r_strength[31];
    assign qx_ext     = $signed({{(ACCW-64){1'b0}}, r_nx});
    assign qy_ext     = $signed({{(ACCW-64){1'b0}}, r_ny});
    assign term_x     = term_neg_x ? -qx_ext : qx_ext;
    assign term_y     = term_neg_y ? -qy_ext : qy_ext;

    // ------------------------------------------------------------------------
    // Target update
    // ------------------------------------------------------------------------
    logic signed [31:0] fxs, fys;
    logic signed [32:0] vsum_x, vsum_y;
    logic signed [32:0] psum_x, psum_y;
    logic signed [31:0] npx, npy;
    logic signed [35:0] vx_ext, vx_x5;
    logic signed [31:0] bvx, bvy, nvx, nvy;
    logic               wall_x, wall_y;

    // saturate the force sums to 32 bits
    always_comb begin
        if (r_fx > ACCW'(ppfs_pkg::S32_MAX))      fxs = ppfs_pkg::S32_MAX;
        else if (r_fx < ACCW'(ppfs_pkg::S32_MIN)) fxs = ppfs_pkg::S32_MIN;
        else                                      fxs = r_fx[31:0];
        if (r_fy > ACCW'(ppfs_pkg::S32_MAX))      fys = ppfs_pkg::S32_MAX;
        else if (r_fy < ACCW'(ppfs_pkg::S32_MIN)) fys = ppfs_pkg::S32_MIN;
        else                                      fys = r_fy[31:0];
    end

    assign vsum_x = 33'(r_tvx) + 33'(fxs);
    assign vsum_y = 33'(r_tvy) + 33'(fys);

    assign psum_x = 33'(r_tpx) + 33'(r_tvx);
    assign psum_y = 33'(r_tpy) + 33'(r_tvy);

    always_comb begin
        if (psum_x[32] != psum_x[31]) npx = psum_x[32] ? ppfs_pkg::S32_MIN : ppfs_pkg::S32_MAX;
        else                          npx = psum_x[31:0];
        if (psum_y[32] != psum_y[31]) npy = psum_y[32] ? ppfs_pkg::S32_MIN : ppfs_pkg::S32_MAX;
        else                          npy = psum_y[31:0];
    end

    assign wall_x = (npx <= 32'sd0) ||
                    ($signed({{17{npx[31]}}, npx}) >= $signed({1'b0, r_area_w, 16'd0}));
    assign wall_y = (npy <= 32'sd0) ||
                    ($signed({{17{npy[31]}}, npy}) >= $signed({1'b0, r_area_h, 16'd0}));

    // x bounce: times -5, saturated
    assign vx_ext = 36'(r_tvx);
    assign vx_x5  = -((vx_ext <<< 2) + vx_ext);

    always_comb begin
        if (vx_x5 > 36'(ppfs_pkg::S32_MAX))      bvx = ppfs_pkg::S32_MAX;
        else if (vx_x5 < 36'(ppfs_pkg::S32_MIN)) bvx = ppfs_pkg::S32_MIN;
        else                                     bvx = vx_x5[31:0];
        // y bounce: negate, the most negative value turns into the most positive
        bvy = (r_tvy == ppfs_pkg::S32_MIN) ? ppfs_pkg::S32_MAX : -r_tvy;
    end

    assign nvx = wall_x ? bvx : r_tvx;
    assign nvy = wall_y ? bvy : r_tvy;

    // ------------------------------------------------------------------------
    // Sequencer: next state and memory strobes
    // ------------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        tmem_we    = 1'b0;
        tmem_waddr = r_tcnt[TIW-1:0];
        tmem_wdata = s_axis_tdata;
        tmem_re    = 1'b0;
        tmem_raddr = r_i[TIW-1:0];
        smem_we    = 1'b0;
        smem_waddr = r_scnt[SIW-1:0];
        smem_re    = 1'b0;
        smem_raddr = r_j[SIW-1:0];
        out_load   = 1'b0;

        case (r_state)
            ppfs_pkg::ST_IDLE: begin
                if (in_fire) begin
                    case (s_axis_tuser)
                        ppfs_pkg::CMD_LOAD_TGT: begin
                            tmem_we = (r_tcnt < TCW'(MAX_TARGETS));
                        end
                        ppfs_pkg::CMD_LOAD_SRC: begin
                            smem_we = (r_scnt < SCW'(MAX_SOURCES));
                        end
                        ppfs_pkg::CMD_RUN: begin
                            if (r_tcnt != '0) begin
                                n_state = ppfs_pkg::ST_T_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ppfs_pkg::ST_T_RD: begin
                tmem_re = 1'b1;
                n_state = ppfs_pkg::ST_T_CAP;
            end
            ppfs_pkg::ST_T_CAP: begin
                n_state = (r_n == '0) ? ppfs_pkg::ST_UPD1 : ppfs_pkg::ST_S_RD;
            end
            ppfs_pkg::ST_S_RD: begin
                if (r_same_set) begin
                    tmem_re    = 1'b1;
                    tmem_raddr = r_j[TIW-1:0];
                end else begin
                    smem_re = 1'b1;
                end
                n_state = ppfs_pkg::ST_S_CAP;
            end
            ppfs_pkg::ST_S_CAP: n_state = ppfs_pkg::ST_SQ1;
            ppfs_pkg::ST_SQ1:   n_state = ppfs_pkg::ST_SQ2;
            ppfs_pkg::ST_SQ2:   n_state = ppfs_pkg::ST_CHK;
            ppfs_pkg::ST_CHK: begin
                n_state = pair_in ? ppfs_pkg::ST_SQRT : ppfs_pkg::ST_NEXT;
            end
            ppfs_pkg::ST_SQRT: begin
                if (r_cnt == ppfs_pkg::SQRT_LAST) begin
                    n_state = ppfs_pkg::ST_MULX;
                end
            end
            ppfs_pkg::ST_MULX: n_state = ppfs_pkg::ST_MULY;
            ppfs_pkg::ST_MULY: n_state = ppfs_pkg::ST_DIV;
            ppfs_pkg::ST_DIV: begin
                if (r_cnt == ppfs_pkg::DIV_LAST) begin
                    n_state = ppfs_pkg::ST_ACC;
                end
            end
            ppfs_pkg::ST_ACC:  n_state = ppfs_pkg::ST_NEXT;
            ppfs_pkg::ST_NEXT: begin
                n_state = pair_last ? ppfs_pkg::ST_UPD1 : ppfs_pkg::ST_S_RD;
            end
            ppfs_pkg::ST_UPD1: n_state = ppfs_pkg::ST_UPD2;
            ppfs_pkg::ST_UPD2: begin
                // hold until the output register can take the result
                if (out_free) begin
                    out_load   = 1'b1;
                    tmem_we    = 1'b1;
                    tmem_waddr = r_i[TIW-1:0];
                    tmem_wdata = {nvy, nvx, npy, npx};
                    n_state    = pass_last_tgt ? ppfs_pkg::ST_IDLE : ppfs_pkg::ST_T_RD;
                end
            end
            default: n_state = ppfs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppfs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // counts and loop indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcnt <= '0;
            r_scnt <= '0;
            r_i    <= '0;
            r_j    <= '0;
            r_n    <= '0;
        end else begin
            if (tmem_we && r_state == ppfs_pkg::ST_IDLE) begin
                r_tcnt <= r_tcnt + 1'b1;
            end
            if (smem_we) begin
                r_scnt <= r_scnt + 1'b1;
            end
            if (in_fire && s_axis_tuser == ppfs_pkg::CMD_RUN) begin
                r_i <= '0;
                r_n <= r_same_set ? NCW'(r_tcnt) : NCW'(r_scnt);
            end
            if (r_state == ppfs_pkg::ST_T_CAP) begin
                r_j <= '0;
            end
            if (r_state == ppfs_pkg::ST_NEXT) begin
                r_j <= r_j + 1'b1;
            end
            if (out_load) begin
                r_i <= r_i + 1'b1;
            end
        end
    end

    // datapath: capture, squares, root, products, divide, sums, update
    always_ff @(posedge i_clk) begin
        case (r_state)
            ppfs_pkg::ST_T_CAP: begin
                r_tpx <= $signed(r_trd[31:0]);
                r_tpy <= $signed(r_trd[63:32]);
                r_tvx <= $signed(r_trd[95:64]);
                r_tvy <= $signed(r_trd[127:96]);
                r_fx  <= '0;
                r_fy  <= '0;
            end
            ppfs_pkg::ST_S_CAP: begin
                r_dx <= 33'(r_tpx) - 33'(src_px);
                r_dy <= 33'(r_tpy) - 33'(src_py);
            end
            ppfs_pkg::ST_SQ1: r_a2 <= 65'(ax) * 65'(ax);
            ppfs_pkg::ST_SQ2: r_d2 <= 66'(r_a2) + 66'(ay) * 66'(ay);
            ppfs_pkg::ST_CHK: begin
                r_rem  <= r_d2[63:0];
                r_root <= '0;
                r_bit  <= 64'd1 << 62;
                r_cnt  <= '0;
            end
            ppfs_pkg::ST_SQRT: begin
                if (sq_take) begin
                    r_rem  <= r_rem - sq_rb;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
            end
            ppfs_pkg::ST_MULX: begin
                r_dist <= r_root[31:0];
                r_nx   <= 64'(65'(ax) * 65'(as_mag));
            end
            ppfs_pkg::ST_MULY: begin
                r_ny  <= 64'(65'(ay) * 65'(as_mag));
                r_rx  <= '0;
                r_ry  <= '0;
                r_cnt <= '0;
            end
            ppfs_pkg::ST_DIV: begin
                r_rx  <= dv_qx ? 32'(dv_tx - {1'b0, r_dist}) : dv_tx[31:0];
                r_ry  <= dv_qy ? 32'(dv_ty - {1'b0, r_dist}) : dv_ty[31:0];
                r_nx  <= {r_nx[62:0], dv_qx};
                r_ny  <= {r_ny[62:0], dv_qy};
                r_cnt <= r_cnt + 1'b1;
            end
            ppfs_pkg::ST_ACC: begin
                r_fx <= r_fx + term_x;
                r_fy <= r_fy + term_y;
            end
            ppfs_pkg::ST_UPD1: begin
                // floor of half the sum
                r_tvx <= vsum_x[32:1];
                r_tvy <= vsum_y[32:1];
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_odata <= {nvy, nvx, npy, npx};
            r_oidx  <= ppfs_pkg::IDX_OUTW'(r_i);
            r_olast <= pass_last_tgt;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_oidx;
    assign m_axis_tlast  = r_olast;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `PPFS_ASSERT_NOW(a_tcnt_bound, i_clk, i_rst_n, r_tcnt <= TCW'(MAX_TARGETS), "target count beyond store")
    `PPFS_ASSERT_NEXT(a_tcnt_pass, i_clk, i_rst_n, r_state != ppfs_pkg::ST_IDLE, $stable(r_tcnt), "target count moved in a pass")
    `PPFS_ASSERT_IMPL(a_div_nonzero, i_clk, i_rst_n, r_state == ppfs_pkg::ST_DIV, r_dist != 32'd0, "divide by zero distance")
    `PPFS_ASSERT_IMPL(a_src_range, i_clk, i_rst_n, r_state == ppfs_pkg::ST_S_RD, r_j < r_n, "source index beyond count")

endmodule

// ===== bench/tb_particle_pair_force_step_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pair force step core: testbench
// Streams load and run words into the core with random gaps on both sides,
// models the Q16.16 pairwise force update alongside it and checks every
// updated target word, field by field, in order.
// ----------------------------------------------------------------------------
module tb_particle_pair_force_step_core;

    // Spare command code: the core must treat it as a no-op.
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int HOLD_CYCLES = 3000;
    localparam int N_TGT = ppfs_pkg::MAX_TARGETS_DEF;
    localparam int N_SRC = ppfs_pkg::MAX_SOURCES_DEF;

    typedef struct {
        logic [1:0]         cmd;
        logic signed [31:0] px, py, vx, vy;
    } t_word;

    typedef struct {
        logic [5:0]         idx;
        logic signed [31:0] px, py, vx, vy;
        logic               last;
    } t_update;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [ppfs_pkg::CFG_IDXW-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [127:0] s_axis_tdata = '0;   // pos_x, pos_y, vel_x, vel_y
    logic [1:0] s_axis_tuser = '0;     // cmd
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;        // new_pos_x, new_pos_y, new_vel_x, new_vel_y
    logic [ppfs_pkg::IDX_OUTW-1:0] m_axis_tuser; // target_index
    logic m_axis_tlast;                // last

    particle_pair_force_step_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow of the core: register settings, particle stores and counts.
    logic signed [31:0] strength_r = ppfs_pkg::STRENGTH_RST;
    logic [15:0] area_w_r = ppfs_pkg::AREA_W_RST;
    logic [15:0] area_h_r = ppfs_pkg::AREA_H_RST;
    logic [15:0] cutoff_r = ppfs_pkg::CUTOFF_RST;
    logic        same_set_r = 1'b0;
    logic signed [31:0] tgt_px [N_TGT], tgt_py [N_TGT], tgt_vx [N_TGT], tgt_vy [N_TGT];
    logic signed [31:0] src_px [N_SRC], src_py [N_SRC];
    int n_tgt = 0;
    int n_src = 0;

    t_word   words_to_send [$];
    t_update pending_updates [$];
    t_word   cur_word;
    int errors = 0;
    int words_sent = 0;
    int updates_seen = 0;
    bit calm = 1'b0;          // phase with no idling at all
    int hold_asked = 0;
    int hold_done = 0;

    function automatic logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic longint unsigned mag(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned rem, root, bitv;
        rem = v;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint pull_term(longint d, longint unsigned span);
        longint unsigned q;
        q = (mag(d) * mag(longint'(strength_r))) / span;
        return ((d < 0) != (strength_r < 0)) ? -longint'(q) : longint'(q);
    endfunction

    // Add the force of one source on one target, if the pair is in range.
    function automatic void add_pull(input logic signed [31:0] tx, ty, sx, sy,
                                     inout longint fx, fy);
        longint dx, dy;
        logic [64:0] d2;
        longint unsigned lim, span;
        dx = longint'(tx) - longint'(sx);
        dy = longint'(ty) - longint'(sy);
        d2 = 65'(mag(dx) * mag(dx)) + 65'(mag(dy) * mag(dy));
        lim = (longint'(cutoff_r) * longint'(cutoff_r)) << 32;
        if (d2[64] || d2 == 0 || d2[63:0] >= lim) return;
        span = floor_root(d2[63:0]);
        fx += pull_term(dx, span);
        fy += pull_term(dy, span);
    endfunction

    // One update pass: step every stored target and queue its result word.
    task automatic advance_particles();
        longint fx, fy, wx, wy;
        t_update u;
        for (int i = 0; i < n_tgt; i++) begin
            fx = 0;
            fy = 0;
            if (same_set_r) begin
                for (int j = 0; j < n_tgt; j++)
                    add_pull(tgt_px[i], tgt_py[i], tgt_px[j], tgt_py[j], fx, fy);
            end else begin
                for (int j = 0; j < n_src; j++)
                    add_pull(tgt_px[i], tgt_py[i], src_px[j], src_py[j], fx, fy);
            end
            wx = longint'(area_w_r) * 65536;
            wy = longint'(area_h_r) * 65536;
            tgt_vx[i] = 32'((longint'(tgt_vx[i]) + longint'(sat32(fx))) >>> 1);
            tgt_vy[i] = 32'((longint'(tgt_vy[i]) + longint'(sat32(fy))) >>> 1);
            tgt_px[i] = sat32(longint'(tgt_px[i]) + longint'(tgt_vx[i]));
            tgt_py[i] = sat32(longint'(tgt_py[i]) + longint'(tgt_vy[i]));
            if (tgt_px[i] <= 0 || longint'(tgt_px[i]) >= wx)
                tgt_vx[i] = sat32(longint'(tgt_vx[i]) * -5);
            if (tgt_py[i] <= 0 || longint'(tgt_py[i]) >= wy)
                tgt_vy[i] = sat32(-longint'(tgt_vy[i]));
            u.idx = i[5:0];
            u.px = tgt_px[i];
            u.py = tgt_py[i];
            u.vx = tgt_vx[i];
            u.vy = tgt_vy[i];
            u.last = (i + 1 == n_tgt);
            pending_updates = {pending_updates, u};
        end
    endtask

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sender: present the next word at the falling edge, hold it until taken.
    bit word_taken = 1'b0;
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (!(s_axis_tvalid && !word_taken)) begin
            if (send_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap--;
            end else if (words_to_send.size() > 0) begin
                cur_word = words_to_send.pop_front();
                s_axis_tuser <= cur_word.cmd;
                s_axis_tdata <= {cur_word.vy, cur_word.vx, cur_word.py, cur_word.px};
                s_axis_tvalid <= 1'b1;
                send_gap = draw_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    int hold_left = 0;
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else if (hold_asked != hold_done) begin
            hold_done = hold_asked;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left = ($urandom_range(0, 99) < 70) ? 0 : draw_gap();
        end
    end

    // Input side: advance the shadow on every accepted word.
    always @(posedge i_clk) begin
        word_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            words_sent++;
            if (cur_word.cmd == ppfs_pkg::CMD_LOAD_TGT && n_tgt < N_TGT) begin
                tgt_px[n_tgt] = cur_word.px;
                tgt_py[n_tgt] = cur_word.py;
                tgt_vx[n_tgt] = cur_word.vx;
                tgt_vy[n_tgt] = cur_word.vy;
                n_tgt++;
            end else if (cur_word.cmd == ppfs_pkg::CMD_LOAD_SRC && n_src < N_SRC) begin
                src_px[n_src] = cur_word.px;
                src_py[n_src] = cur_word.py;
                n_src++;
            end else if (cur_word.cmd == ppfs_pkg::CMD_RUN) begin
                advance_particles();
            end
        end
    end

    // Output side: compare each result word with the oldest prediction.
    always @(posedge i_clk) begin
        t_update e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            updates_seen++;
            if (pending_updates.size() == 0) begin
                $error("result word with no update pending");
                errors++;
            end else begin
                e = pending_updates.pop_front();
                if (m_axis_tuser !== e.idx) begin
                    $error("target_index: expected %0d, got %0d", e.idx, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[31:0] !== e.px) begin
                    $error("new_pos_x: expected %h, got %h", e.px, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[63:32] !== e.py) begin
                    $error("new_pos_y: expected %h, got %h", e.py, m_axis_tdata[63:32]);
                    errors++;
                end
                if (m_axis_tdata[95:64] !== e.vx) begin
                    $error("new_vel_x: expected %h, got %h", e.vx, m_axis_tdata[95:64]);
                    errors++;
                end
                if (m_axis_tdata[127:96] !== e.vy) begin
                    $error("new_vel_y: expected %h, got %h", e.vy, m_axis_tdata[127:96]);
                    errors++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send(logic [1:0] cmd, logic signed [31:0] px, py, vx, vy);
        t_word w;
        w.cmd = cmd;
        w.px = px;
        w.py = py;
        w.vx = vx;
        w.vy = vy;
        words_to_send = {words_to_send, w};
    endtask

    // Hold until every word is taken and every update has come back.
    task automatic drain();
        do begin
            while (words_to_send.size() > 0 || s_axis_tvalid || pending_updates.size() > 0)
                @(negedge i_clk);
            repeat (60) @(negedge i_clk);
        end while (words_to_send.size() > 0 || s_axis_tvalid || pending_updates.size() > 0);
    endtask

    task automatic write_reg(ppfs_pkg::t_cfg_reg idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        case (idx)
            ppfs_pkg::CFG_STRENGTH: strength_r = val;
            ppfs_pkg::CFG_AREA_W:   area_w_r = val[15:0];
            ppfs_pkg::CFG_AREA_H:   area_h_r = val[15:0];
            ppfs_pkg::CFG_CUTOFF:   cutoff_r = val[15:0];
            ppfs_pkg::CFG_SAME_SET: same_set_r = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    function automatic logic signed [31:0] near_pos();
        return $urandom_range(0, 300 * 65536);
    endfunction

    function automatic logic signed [31:0] small_vel();
        if ($urandom_range(0, 9) == 0) return $urandom();
        return $signed($urandom_range(0, 8 * 65536)) - 32'sd262144;
    endfunction

    initial begin
        int loads_t, loads_s, r;
        logic signed [31:0] sx, sy;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty pass, extremes, no sources, spare command.
        send(ppfs_pkg::CMD_RUN, 0, 0, 0, 0);
        send(ppfs_pkg::CMD_LOAD_TGT, 32'sh7FFF_FFFF, 32'sh8000_0000,
             32'sh7FFF_FFFF, 32'sh8000_0000);
        send(ppfs_pkg::CMD_LOAD_TGT, 32'sh8000_0000, 32'sh7FFF_FFFF,
             32'sh8000_0000, 32'sh7FFF_FFFF);
        send(ppfs_pkg::CMD_LOAD_TGT, 100 << 16, 100 << 16, 32'sh0001_8000, -32'sh0000_4000);
        send(CMD_SPARE, '1, '1, '1, '1);
        send(ppfs_pkg::CMD_RUN, 0, 0, 0, 0);
        drain();
        // Source right on a target (coincident) and one close beside it.
        sx = tgt_px[2];
        sy = tgt_py[2];
        send(ppfs_pkg::CMD_LOAD_SRC, sx, sy, 0, 0);
        send(ppfs_pkg::CMD_LOAD_SRC, sx + (3 << 16), sy - (4 << 16), '1, '1);
        send(ppfs_pkg::CMD_RUN, 0, 0, 0, 0);
        drain();
        write_reg(ppfs_pkg::CFG_SAME_SET, 1);
        write_reg(ppfs_pkg::CFG_STRENGTH, 32'h8000_0000);
        write_reg(ppfs_pkg::CFG_CUTOFF, 16'hFFFF);
        write_reg(ppfs_pkg::CFG_AREA_W, 1);
        write_reg(ppfs_pkg::CFG_AREA_H, 16'hFFFF);
        send(ppfs_pkg::CMD_RUN, 0, 0, 0, 0);
        drain();
        write_reg(ppfs_pkg::CFG_STRENGTH, 32'h7FFF_FFFF);
        write_reg(ppfs_pkg::CFG_AREA_W, 16'hFFFF);
        write_reg(ppfs_pkg::CFG_AREA_H, 1);
        write_reg(ppfs_pkg::CFG_CUTOFF, 1);
        send(ppfs_pkg::CMD_RUN, 0, 0, 0, 0);
        drain();

        // Random phases: clustered particles, varied settings between phases.
        loads_t = n_tgt;
        loads_s = n_src;
        for (int ph = 0; ph < 6; ph++) begin
            calm = (ph == 1);
            r = $urandom_range(0, 3);
            write_reg(ppfs_pkg::CFG_STRENGTH, r == 0 ? $urandom() :
                      r == 1 ? 32'h8000_0000 : $urandom_range(0, 4 << 16) - (2 << 16));
            write_reg(ppfs_pkg::CFG_AREA_W, $urandom_range(0, 4) == 0 ?
                      $urandom_range(1, 65535) : $urandom_range(50, 400));
            write_reg(ppfs_pkg::CFG_AREA_H, $urandom_range(0, 4) == 0 ?
                      $urandom_range(1, 65535) : $urandom_range(50, 400));
            write_reg(ppfs_pkg::CFG_CUTOFF, $urandom_range(0, 4) == 0 ?
                      $urandom_range(1, 65535) : $urandom_range(10, 250));
            write_reg(ppfs_pkg::CFG_SAME_SET, $urandom_range(0, 1));
            if (ph == 3) begin
                // Hold the receiver off through a pass while loads queue behind it.
                hold_asked++;
                send(ppfs_pkg::CMD_RUN, $urandom(), $urandom(), $urandom(), $urandom());
                send(ppfs_pkg::CMD_LOAD_SRC, near_pos(), near_pos(), $urandom(), $urandom());
                send(ppfs_pkg::CMD_RUN, 0, 0, 0, 0);
                loads_s++;
            end
            for (int k = 0; k < 25; k++) begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    send(CMD_SPARE, $urandom(), $urandom(), $urandom(), $urandom());
                else if (r < 25 && loads_t < 5) begin
                    send(ppfs_pkg::CMD_LOAD_TGT, near_pos(), near_pos(),
                         small_vel(), small_vel());
                    loads_t++;
                end else if (r < 40 && loads_s < 6) begin
                    send(ppfs_pkg::CMD_LOAD_SRC, near_pos(), near_pos(),
                         $urandom(), $urandom());
                    loads_s++;
                end else
                    send(ppfs_pkg::CMD_RUN, $urandom(), $urandom(), $urandom(), $urandom());
            end
            drain();
        end

        // Fill both stores past their depth, then run against sources and as one set.
        calm = 1'b0;
        write_reg(ppfs_pkg::CFG_CUTOFF, ppfs_pkg::CUTOFF_RST);
        write_reg(ppfs_pkg::CFG_STRENGTH, ppfs_pkg::STRENGTH_RST);
        write_reg(ppfs_pkg::CFG_SAME_SET, 0);
        for (int k = loads_t; k < N_TGT + 2; k++)
            send(ppfs_pkg::CMD_LOAD_TGT, $urandom(), $urandom(), $urandom(), $urandom());
        for (int k = loads_s; k < N_SRC + 2; k++)
            send(ppfs_pkg::CMD_LOAD_SRC, $urandom(), $urandom(), $urandom(), $urandom());
        send(ppfs_pkg::CMD_RUN, 0, 0, 0, 0);
        drain();
        write_reg(ppfs_pkg::CFG_SAME_SET, 1);
        send(ppfs_pkg::CMD_RUN, 0, 0, 0, 0);
        drain();

        $display("Sent %0d words; checked %0d target updates over empty, sparse and full",
                 words_sent, updates_seen);
        $display("stores, several register settings and a long output hold-off.");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ===== particle_pair_force_step_core.f =====
+incdir+rtl/core
rtl/core/ppfs_pkg.sv
rtl/core/particle_pair_force_step_core.sv
bench/tb_particle_pair_force_step_core.sv
